[design/lcgsc_pkg.sv]
// shared types, codes and constants of the lcg shuffle cbc byte cipher
// micro-operation codes, sequencer/datapath structs, generator step
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lcgsc_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int IDX_W       = $clog2(BLOCK_BYTES);

    localparam int unsigned LCG_MUL = 32'd1103515245;
    localparam int unsigned LCG_ADD = 32'd12345;
    localparam logic [7:0]  LcgMulLo = 8'(LCG_MUL % 256);
    localparam logic [7:0]  LcgAddLo = 8'(LCG_ADD % 256);

    localparam int CFG_ADDR_W = 3;
    localparam logic [0:0] REG_KEY_SEED = 1'b0;

    typedef logic [3:0] op_t;

    localparam op_t OP_NOP     = 4'd0;
    localparam op_t OP_LOADKEY = 4'd1;
    localparam op_t OP_IVSTEP  = 4'd2;
    localparam op_t OP_WRBYTE  = 4'd3;
    localparam op_t OP_SETPAD  = 4'd4;
    localparam op_t OP_PADSTEP = 4'd5;
    localparam op_t OP_KSSTEP  = 4'd6;
    localparam op_t OP_SWAPRD  = 4'd7;
    localparam op_t OP_SWAPW1  = 4'd8;
    localparam op_t OP_SWAPW2  = 4'd9;
    localparam op_t OP_OUTRD   = 4'd10;
    localparam op_t OP_EMIT    = 4'd11;
    localparam op_t OP_CLOSE   = 4'd12;

    typedef struct packed {
        op_t  op;
        logic take;
    } ctrl_t;

    typedef struct packed {
        logic item_live;
        logic open;
        logic present;
        logic end_flag;
        logic final_blk;
        logic cnt_last;
        logic fill_full;
        logic out_free;
    } status_t;

    function automatic logic [7:0] lcg_next(input logic [7:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'(LcgMulLo) + 16'(LcgAddLo);
        return p[7:0];
    endfunction

endpackage

`default_nettype wire

[design/lcg_shuffle_cbc_byte_cipher.sv]
// Byte-stream block cipher: plaintext bytes are gathered into 16-byte blocks,
// chained (CBC) with the previous ciphertext, shuffled by 16 keystream-driven
// swaps and XORed with the keystream from an 8-bit LCG seeded by key_seed. A
// microcoded sequencer runs the datapath one step per cycle, except while an
// emit step holds for a busy output register; a byte is accepted only while
// the sequencer idles. Opening a message adds the IV draw; each encrypted
// block adds 16 keystream draws, 16 swaps of a read and two writes each on
// the single-write-port work memory and 16 read and emit pairs, plus any
// output stall. End of message adds the padding loop, one more block and a
// closing step. The result register lets the next byte be accepted while the
// last ciphertext byte still waits.
// top level: apb key register, sequencer and datapath; depends on lcgsc_pkg, lcgsc_seq and lcgsc_dp
`timescale 1ns / 1ps
`default_nettype none

module lcg_shuffle_cbc_byte_cipher (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lcgsc_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,  // plain_byte
    input  wire logic                             s_tuser,  // byte_present
    input  wire logic                             s_tlast,  // end_of_message
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [7:0]                            m_tdata,  // cipher_byte
    output logic                                  m_tuser,  // last_of_block
    output logic                                  m_tlast   // last_of_message
);
    import lcgsc_pkg::*;

    logic [7:0] key_reg;
    ctrl_t      ctrl;
    status_t    status;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[CFG_ADDR_W-1] == REG_KEY_SEED) begin
            key_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        unique case (paddr[CFG_ADDR_W-1])
            REG_KEY_SEED: prdata = {24'd0, key_reg};
            default:      prdata = '0;
        endcase
    end

    lcgsc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    lcgsc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .status   (status),
        .key_seed (key_reg),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    assign s_tready = ctrl.take;

endmodule

`default_nettype wire

[design/lcgsc_seq.sv]
// microcode sequencer: step counter, control word table, conditional jumps
// depends on lcgsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module lcgsc_seq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lcgsc_pkg::status_t status,
    output lcgsc_pkg::ctrl_t       ctrl
);
    import lcgsc_pkg::*;

    localparam int PC_W = 5;

    typedef logic [3:0] cond_t;

    localparam cond_t J_NONE      = 4'd0;
    localparam cond_t J_ALWAYS    = 4'd1;
    localparam cond_t J_WAIT      = 4'd2;
    localparam cond_t J_OPEN      = 4'd3;
    localparam cond_t J_NOBYTE    = 4'd4;
    localparam cond_t J_FULL      = 4'd5;
    localparam cond_t J_NOEND     = 4'd6;
    localparam cond_t J_NOTLAST   = 4'd7;
    localparam cond_t J_NOTFINAL  = 4'd8;

    localparam logic [PC_W-1:0] S_IDLE    = 5'd0;
    localparam logic [PC_W-1:0] S_CHKOPEN = 5'd1;
    localparam logic [PC_W-1:0] S_LOADKEY = 5'd2;
    localparam logic [PC_W-1:0] S_IV      = 5'd3;
    localparam logic [PC_W-1:0] S_CHKBYTE = 5'd4;
    localparam logic [PC_W-1:0] S_WRBYTE  = 5'd5;
    localparam logic [PC_W-1:0] S_CHKEND  = 5'd6;
    localparam logic [PC_W-1:0] S_SETPAD  = 5'd7;
    localparam logic [PC_W-1:0] S_PAD     = 5'd8;
    localparam logic [PC_W-1:0] S_KS      = 5'd9;
    localparam logic [PC_W-1:0] S_SWAPRD  = 5'd10;
    localparam logic [PC_W-1:0] S_SWAPW1  = 5'd11;
    localparam logic [PC_W-1:0] S_SWAPW2  = 5'd12;
    localparam logic [PC_W-1:0] S_OUTRD   = 5'd13;
    localparam logic [PC_W-1:0] S_EMIT    = 5'd14;
    localparam logic [PC_W-1:0] S_RETURN  = 5'd15;
    localparam logic [PC_W-1:0] S_CLOSE   = 5'd16;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            wait_out;
    } ctl_word_t;

    function automatic ctl_word_t cw(input op_t o, input cond_t c,
                                     input logic [PC_W-1:0] t, input logic w);
        ctl_word_t r;
        r.op       = o;
        r.cond     = c;
        r.target   = t;
        r.wait_out = w;
        return r;
    endfunction

    function automatic ctl_word_t rom_word(input logic [PC_W-1:0] step);
        ctl_word_t r;
        unique case (step)
            S_IDLE:    r = cw(OP_NOP,     J_WAIT,     S_IDLE,    1'b0);
            S_CHKOPEN: r = cw(OP_NOP,     J_OPEN,     S_CHKBYTE, 1'b0);
            S_LOADKEY: r = cw(OP_LOADKEY, J_NONE,     S_IDLE,    1'b0);
            S_IV:      r = cw(OP_IVSTEP,  J_NOTLAST,  S_IV,      1'b0);
            S_CHKBYTE: r = cw(OP_NOP,     J_NOBYTE,   S_CHKEND,  1'b0);
            S_WRBYTE:  r = cw(OP_WRBYTE,  J_FULL,     S_KS,      1'b0);
            S_CHKEND:  r = cw(OP_NOP,     J_NOEND,    S_IDLE,    1'b0);
            S_SETPAD:  r = cw(OP_SETPAD,  J_NONE,     S_IDLE,    1'b0);
            S_PAD:     r = cw(OP_PADSTEP, J_NOTLAST,  S_PAD,     1'b0);
            S_KS:      r = cw(OP_KSSTEP,  J_NOTLAST,  S_KS,      1'b0);
            S_SWAPRD:  r = cw(OP_SWAPRD,  J_NONE,     S_IDLE,    1'b0);
            S_SWAPW1:  r = cw(OP_SWAPW1,  J_NONE,     S_IDLE,    1'b0);
            S_SWAPW2:  r = cw(OP_SWAPW2,  J_NOTLAST,  S_SWAPRD,  1'b0);
            S_OUTRD:   r = cw(OP_OUTRD,   J_NONE,     S_IDLE,    1'b0);
            S_EMIT:    r = cw(OP_EMIT,    J_NOTLAST,  S_OUTRD,   1'b1);
            S_RETURN:  r = cw(OP_NOP,     J_NOTFINAL, S_CHKEND,  1'b0);
            S_CLOSE:   r = cw(OP_CLOSE,   J_ALWAYS,   S_IDLE,    1'b0);
            default:   r = cw(OP_NOP,     J_ALWAYS,   S_IDLE,    1'b0);
        endcase
        return r;
    endfunction

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ctl_word_t       word;
    logic            hold;
    logic            jump;

    assign word = rom_word(pc_reg);
    assign hold = word.wait_out && !status.out_free;

    always_comb begin
        unique case (word.cond)
            J_NONE:     jump = 1'b0;
            J_ALWAYS:   jump = 1'b1;
            J_WAIT:     jump = !status.item_live;
            J_OPEN:     jump = status.open;
            J_NOBYTE:   jump = !status.present;
            J_FULL:     jump = status.fill_full;
            J_NOEND:    jump = !status.end_flag;
            J_NOTLAST:  jump = !status.cnt_last;
            J_NOTFINAL: jump = !status.final_blk;
            default:    jump = 1'b1;
        endcase
    end

    always_comb begin
        if (hold) begin
            pc_next = pc_reg;
        end else if (jump) begin
            pc_next = word.target;
        end else begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= S_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.op   = hold ? OP_NOP : word.op;
    assign ctrl.take = (pc_reg == S_IDLE);

    a_emit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == S_EMIT && !status.out_free) |=> pc_reg == S_EMIT)
        else $error("sequencer left emit step while output was blocked");

    a_close_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg == S_CLOSE |=> pc_reg == S_IDLE)
        else $error("close step did not return to idle");

    a_key_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg == S_LOADKEY |-> !status.open)
        else $error("key reload while a message is open");

endmodule

`default_nettype wire

[design/lcgsc_dp.sv]
// datapath: generator, chain and keystream registers, work memory, output register
// depends on lcgsc_pkg; driven by lcgsc_seq
`timescale 1ns / 1ps
`default_nettype none

module lcgsc_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire lcgsc_pkg::ctrl_t   ctrl,
    output lcgsc_pkg::status_t      status,
    input  wire logic [7:0]         key_seed,
    input  wire logic               s_tvalid,
    input  wire logic [7:0]         s_tdata,
    input  wire logic               s_tuser,
    input  wire logic               s_tlast,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,
    output logic                    m_tuser,
    output logic                    m_tlast
);
    import lcgsc_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_BYTES - 1);

    logic [7:0]       lcg_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] fill_reg;
    logic             open_reg;
    logic             final_reg;
    logic [7:0]       pad_reg;
    logic [7:0]       byte_reg;
    logic             present_reg;
    logic             end_reg;
    logic [7:0]       chain_reg [BLOCK_BYTES];
    logic [7:0]       ks_reg [BLOCK_BYTES];
    logic [7:0]       work_mem [BLOCK_BYTES];
    logic [7:0]       rd_a_reg;
    logic [7:0]       rd_b_reg;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [7:0]       m_data_reg;
    logic             m_block_reg;
    logic             m_msg_reg;

    logic [7:0]       lcg_step;
    logic [7:0]       ks_cur;
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
    logic [7:0]       emit_byte;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             out_free;

    assign lcg_step  = lcg_next(lcg_reg);
    assign ks_cur    = ks_reg[cnt_reg];
    assign addr_a    = ks_cur[IDX_W-1:0];
    assign addr_b    = ks_cur[2*IDX_W-1:IDX_W];
    assign emit_byte = rd_a_reg ^ ks_cur;
    assign out_free  = !m_valid_reg || m_tready;

    // single write port of the work memory
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = cnt_reg;
        wr_data = pad_reg;
        case (ctrl.op)
            OP_WRBYTE: begin
                wr_addr = fill_reg;
                wr_data = byte_reg ^ chain_reg[fill_reg];
            end
            OP_PADSTEP: begin
                wr_addr = cnt_reg;
                wr_data = pad_reg ^ chain_reg[cnt_reg];
            end
            OP_SWAPW1: begin
                wr_addr = addr_a;
                wr_data = rd_b_reg;
            end
            OP_SWAPW2: begin
                wr_addr = addr_b;
                wr_data = rd_a_reg;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            work_mem[wr_addr] <= wr_data;
        end
        if (ctrl.op == OP_SWAPRD) begin
            rd_a_reg <= work_mem[addr_a];
            rd_b_reg <= work_mem[addr_b];
        end else if (ctrl.op == OP_OUTRD) begin
            rd_a_reg <= work_mem[cnt_reg];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (ctrl.take && s_tvalid) begin
            byte_reg    <= s_tdata;
            present_reg <= s_tuser;
            end_reg     <= s_tlast;
        end
        if (ctrl.op == OP_IVSTEP) begin
            chain_reg[cnt_reg] <= lcg_step;
        end else if (ctrl.op == OP_EMIT) begin
            chain_reg[cnt_reg] <= emit_byte;
        end
        if (ctrl.op == OP_KSSTEP) begin
            ks_reg[cnt_reg] <= lcg_step;
        end
        if (ctrl.op == OP_SETPAD) begin
            pad_reg <= 8'(BLOCK_BYTES) - 8'(fill_reg);
        end
        if (ctrl.op == OP_EMIT) begin
            m_data_reg  <= emit_byte;
            m_block_reg <= (cnt_reg == LAST_IDX);
            m_msg_reg   <= final_reg && (cnt_reg == LAST_IDX);
        end
    end

    always_comb begin
        if (ctrl.op == OP_EMIT) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcg_reg     <= '0;
            cnt_reg     <= '0;
            fill_reg    <= '0;
            open_reg    <= 1'b0;
            final_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            case (ctrl.op)
                OP_LOADKEY: begin
                    lcg_reg  <= key_seed;
                    cnt_reg  <= '0;
                    fill_reg <= '0;
                    open_reg <= 1'b1;
                end
                OP_IVSTEP, OP_KSSTEP: begin
                    lcg_reg <= lcg_step;
                    cnt_reg <= cnt_reg + IDX_W'(1);
                end
                OP_WRBYTE: begin
                    fill_reg  <= fill_reg + IDX_W'(1);
                    final_reg <= 1'b0;
                end
                OP_SETPAD: begin
                    cnt_reg   <= fill_reg;
                    final_reg <= 1'b1;
                end
                OP_PADSTEP, OP_SWAPW2, OP_EMIT: begin
                    cnt_reg <= cnt_reg + IDX_W'(1);
                end
                OP_CLOSE: begin
                    open_reg <= 1'b0;
                    fill_reg <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign status.item_live = s_tvalid && (s_tuser || s_tlast);
    assign status.open      = open_reg;
    assign status.present   = present_reg;
    assign status.end_flag  = end_reg;
    assign status.final_blk = final_reg;
    assign status.cnt_last  = (cnt_reg == LAST_IDX);
    assign status.fill_full = (fill_reg == LAST_IDX);
    assign status.out_free  = out_free;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_block_reg;
    assign m_tlast  = m_msg_reg;

    a_emit_open: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == OP_EMIT |-> open_reg)
        else $error("ciphertext emitted with no open message");

endmodule

`default_nettype wire

[verif/cipher_byte_checker.sv]
// checker for the lcg shuffle cbc byte cipher: watches the key register port and
// both word channels, predicts the ciphertext words and compares them in order
// depends on lcgsc_pkg
`timescale 1ns / 1ps

module cipher_byte_checker
    import lcgsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,
    input  logic                  m_tuser,
    input  logic                  m_tlast,
    output int                    mismatch_count,
    output int                    words_owed
);

    localparam logic [CFG_ADDR_W-1:0] KEY_SEED_ADDR = {REG_KEY_SEED, 2'b00};

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       last_of_block;
        logic       last_of_message;
    } cipher_word_t;

    cipher_word_t expected_cipher[$];
    cipher_word_t got_word;
    cipher_word_t want_word;

    logic [7:0] key_seed;
    logic [7:0] plain_block [BLOCK_BYTES];
    logic [7:0] chain_block [BLOCK_BYTES];
    logic [7:0] lcg_x;
    int         fill;
    logic       msg_open;

    function automatic logic [7:0] lcg_step(input logic [7:0] x);
        logic [31:0] p;
        p = {24'd0, x} * LCG_MUL + LCG_ADD;
        return p[7:0];
    endfunction

    task automatic encrypt_plain_block(input logic final_blk);
        logic [7:0]   work [BLOCK_BYTES];
        logic [7:0]   ks [BLOCK_BYTES];
        logic [3:0]   a;
        logic [3:0]   b;
        logic [7:0]   t;
        cipher_word_t w;
        for (int i = 0; i < BLOCK_BYTES; i++) work[i] = plain_block[i] ^ chain_block[i];
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            lcg_x = lcg_step(lcg_x);
            ks[i] = lcg_x;
        end
        // keystream-driven swaps, low nibble against high nibble
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            a = ks[i][3:0];
            b = ks[i][7:4];
            t = work[a];
            work[a] = work[b];
            work[b] = t;
        end
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            chain_block[i] = work[i] ^ ks[i];
            w.cipher_byte = chain_block[i];
            w.last_of_block = (i == BLOCK_BYTES - 1);
            w.last_of_message = final_blk && (i == BLOCK_BYTES - 1);
            expected_cipher.push_back(w);
        end
    endtask

    task automatic predict_plain_word(input logic [7:0] b, input logic present, input logic eom);
        logic [7:0] pad;
        if (present || eom) begin
            if (!msg_open) begin
                // message start: seed the generator and draw the iv
                lcg_x = key_seed;
                for (int i = 0; i < BLOCK_BYTES; i++) begin
                    lcg_x = lcg_step(lcg_x);
                    chain_block[i] = lcg_x;
                end
                fill = 0;
                msg_open = 1'b1;
            end
            if (present) begin
                plain_block[fill] = b;
                fill++;
                if (fill == BLOCK_BYTES) begin
                    encrypt_plain_block(1'b0);
                    fill = 0;
                end
            end
            if (eom) begin
                pad = 8'(BLOCK_BYTES - fill);
                for (int i = fill; i < BLOCK_BYTES; i++) plain_block[i] = pad;
                encrypt_plain_block(1'b1);
                fill = 0;
                msg_open = 1'b0;
            end
        end
    endtask

    initial begin
        mismatch_count = 0;
        words_owed = 0;
        key_seed = 8'h00;
        lcg_x = 8'h00;
        fill = 0;
        msg_open = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            key_seed = 8'h00;
            lcg_x = 8'h00;
            fill = 0;
            msg_open = 1'b0;
            expected_cipher.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == KEY_SEED_ADDR)
                key_seed = pwdata[7:0];
            if (s_tvalid && s_tready)
                predict_plain_word(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready) begin
                got_word = {m_tdata, m_tuser, m_tlast};
                if (expected_cipher.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected cipher word: byte %h lob %b lom %b", $realtime,
                                 got_word.cipher_byte, got_word.last_of_block,
                                 got_word.last_of_message);
                end else begin
                    want_word = expected_cipher.pop_front();
                    if (got_word.cipher_byte !== want_word.cipher_byte
                            || got_word.last_of_block !== want_word.last_of_block
                            || got_word.last_of_message !== want_word.last_of_message) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: cipher word mismatch: expected byte %h lob %b lom %b, got byte %h lob %b lom %b",
                                     $realtime, want_word.cipher_byte, want_word.last_of_block,
                                     want_word.last_of_message, got_word.cipher_byte,
                                     got_word.last_of_block, got_word.last_of_message);
                    end
                end
            end
        end
        words_owed = expected_cipher.size();
    end

endmodule

[verif/tb_top.sv]
// testbench top for lcg_shuffle_cbc_byte_cipher: clock, reset, key register
// writes and plaintext stimulus; checking is left to cipher_byte_checker
// depends on lcgsc_pkg, lcg_shuffle_cbc_byte_cipher and cipher_byte_checker
`timescale 1ns / 1ps

module tb_top;
    import lcgsc_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] KEY_SEED_ADDR = {REG_KEY_SEED, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR    = {~REG_KEY_SEED, 2'b00};
    localparam int RANDOM_WORDS  = 220;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    int   mismatch_count;
    int   words_owed;
    int   words_sent;
    logic tx_calm;
    logic rx_calm;
    logic hold_req;
    logic hold_done;

    lcg_shuffle_cbc_byte_cipher dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    cipher_byte_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .mismatch_count(mismatch_count), .words_owed(words_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: random back-pressure, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            m_tready = aresetn && (rx_calm || $urandom_range(0, 99) >= 13);
        end
    end

    task automatic send_word(input logic [7:0] b, input logic present, input logic eom,
                             input bit noise);
        if (!tx_calm && $urandom_range(0, 99) < 13) begin
            s_tvalid = 1'b0;
            s_tdata = 8'($urandom);
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tuser = present;
        s_tlast = eom;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (!noise) words_sent++;
    endtask

    // wait for every owed word, then let any byte still in flight finish
    task automatic settle_block;
        s_tvalid = 1'b0;
        while (words_owed != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic write_key_seed;
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 3))
            0: v[7:0] = 8'h00;
            1: v[7:0] = 8'hff;
            default: ;
        endcase
        apb_write(KEY_SEED_ADDR, v);
    endtask

    initial begin
        int  n;
        int  msg;
        bit  tail_with_byte;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        hold_req = 1'b0;
        words_sent = 0;
        aresetn = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // reset key: empty message, then words that carry nothing
        send_word(8'ha5, 1'b0, 1'b1, 1'b0);
        send_word(8'hff, 1'b0, 1'b0, 1'b1);
        send_word(8'h00, 1'b0, 1'b0, 1'b1);
        settle_block();
        apb_write(KEY_SEED_ADDR, 32'hffff_ffff);
        apb_write(SPARE_ADDR, 32'h0000_005a);
        // full block closed on its last byte: data block plus padding block
        for (int i = 0; i < BLOCK_BYTES; i++)
            send_word((i == 0) ? 8'h00 : (i == 1) ? 8'hff : (i < 10) ? 8'(1 << (i - 2))
                      : 8'($urandom), 1'b1, i == BLOCK_BYTES - 1, 1'b0);
        settle_block();
        apb_write(KEY_SEED_ADDR, 32'h0000_0000);
        send_word(8'hff, 1'b1, 1'b1, 1'b0);

        words_sent = 0;
        msg = 0;
        while (words_sent < RANDOM_WORDS) begin
            msg++;
            n = ($urandom_range(0, 7) == 0) ? BLOCK_BYTES * $urandom_range(1, 2)
                                            : $urandom_range(0, 40);
            if (msg == 3) begin
                hold_req = 1'b1;
                n = 48;
            end
            if (msg == 6 || msg == 7) n = 20;
            tx_calm = (msg == 5);
            rx_calm = (msg == 5);
            if (msg == 5) n = 40;
            if (msg % 4 == 0) begin
                settle_block();
                write_key_seed();
            end
            tail_with_byte = (n > 0) && $urandom_range(0, 1);
            for (int i = 0; i < n; i++) begin
                // key change inside an open message, and a plain drain pause
                if (msg == 6 && i == n / 2) begin
                    settle_block();
                    write_key_seed();
                end
                if (msg == 7 && i == n / 2) settle_block();
                if ($urandom_range(0, 19) == 0)
                    send_word(8'($urandom), 1'b0, 1'b0, 1'b1);
                send_word(8'($urandom), 1'b1, tail_with_byte && i == n - 1, 1'b0);
            end
            if (!tail_with_byte) send_word(8'($urandom), 1'b0, 1'b1, 1'b0);
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        s_tvalid = 1'b0;
        while (words_owed != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
